### sv/h2m_pkg.sv
// ----------------------------------------------------------------------------
// h2m_pkg: shared definitions for the hz to mel converter
// Fixed-point formats, derived widths and the log2 interpolation table.
// ----------------------------------------------------------------------------
package h2m_pkg;

    // field formats
    localparam int IN_FRAC_BITS      = 8;
    localparam int OUT_FRAC_BITS     = 16;
    localparam int LOG_TABLE_ENTRIES = 64;

    localparam int FREQ_W = 24;
    localparam int MEL_W  = 23;
    localparam logic [MEL_W-1:0] MEL_MAX = {MEL_W{1'b1}};

    // pipeline depth
    localparam int STAGES = 7;

    // log2 values in Q.30
    localparam int Q_FRAC = 30;
    localparam logic [63:0] Q30_ONE = 64'd1 << Q_FRAC;

    // break point 1000 Hz in input format and the leading-one offset at it
    localparam int BRK_W = FREQ_W + 2;
    localparam logic [BRK_W-1:0] BREAK_HZ = BRK_W'(64'd1000 << IN_FRAC_BITS);
    localparam int E_BASE = IN_FRAC_BITS + 9;
    localparam int POS_W  = 5;
    localparam int E_W    = 4;

    // mantissa fraction and table index
    localparam int FRAC_W    = 31;
    localparam int TAB_IDX_W = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int SCALED_W  = FRAC_W + TAB_IDX_W;

    // log-region scale factor 27*ln(2)/ln(6.4) in Q.24
    localparam int K_W = 28;
    localparam logic [K_W-1:0] K_Q24 = 28'd169145881;

    // log difference and its split product
    localparam int D_W    = E_W + Q_FRAC;
    localparam int DL_W   = D_W / 2;
    localparam int DH_W   = D_W - DL_W;
    localparam int PL_W   = DL_W + K_W;
    localparam int PH_W   = DH_W + K_W;
    localparam int P_W    = D_W + K_W;
    localparam int MUL_SH = 54 - OUT_FRAC_BITS;
    localparam int LOGM_W = P_W + 1 - MUL_SH;
    localparam logic [P_W:0] MUL_ROUND = (P_W+1)'(64'd1 << (MUL_SH - 1));

    // mel at the break, plain and saturated
    localparam logic [63:0] MEL_BREAK64 = 64'd15 << OUT_FRAC_BITS;
    localparam logic [MEL_W-1:0] MEL_AT_BREAK =
        (MEL_BREAK64 > 64'(MEL_MAX)) ? MEL_MAX : MEL_W'(MEL_BREAK64);

    // linear region: floor((3x*2^OUT + 100*2^IN) / 2^(IN+3)) / 25
    localparam int LIN_A_W     = FREQ_W + 2 + OUT_FRAC_BITS + 1;
    localparam int LIN_SH      = IN_FRAC_BITS + 3;
    localparam int LIN_N_W     = LIN_A_W - LIN_SH;
    localparam int LIN_Q_W     = LIN_N_W - 4;
    localparam int LIN_P_W     = LIN_N_W + LIN_Q_W;
    localparam logic [LIN_A_W-1:0] LIN_BIAS = LIN_A_W'(64'd100 << IN_FRAC_BITS);
    localparam logic [LIN_Q_W-1:0] LIN_RECIP = LIN_Q_W'((64'd1 << LIN_N_W) / 64'd25);

    // log2 of y in Q.30 within [1,2] by repeated squaring, truncated
    function automatic logic [63:0] log2_q30(input logic [63:0] y_in);
        logic [63:0] y;
        logic [63:0] res;
        y   = y_in;
        res = '0;
        if (y >= 2 * Q30_ONE)
            return Q30_ONE;
        if (y < Q30_ONE)
            return '0;
        for (int k = Q_FRAC - 1; k >= 0; k--)
        begin
            y = (y * y) >> Q_FRAC;
            if (y >= 2 * Q30_ONE)
            begin
                y      = y >> 1;
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

    typedef logic [LOG_TABLE_ENTRIES:0][Q_FRAC:0] log_tab_t;

    // table of log2(1 + i/N), i = 0..N
    function automatic log_tab_t build_log_table();
        log_tab_t tab;
        logic [63:0] arg;
        for (int i = 0; i <= LOG_TABLE_ENTRIES; i++)
        begin
            arg    = (64'(LOG_TABLE_ENTRIES + i) << Q_FRAC) / 64'(LOG_TABLE_ENTRIES);
            tab[i] = (Q_FRAC+1)'(log2_q30(arg));
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TABLE = build_log_table();

    // fraction part of log2(1000) = 9 + log2(1000/512)
    localparam logic [Q_FRAC:0] LOG_1000_FRAC = (Q_FRAC+1)'(log2_q30(64'd1000 << 21));

endpackage

### sv/hz_to_mel_converter_unit.sv
// ----------------------------------------------------------------------------
// hz_to_mel_converter_unit: registered pipeline from input to output transaction.
// Throughput one transaction per cycle; each of the 7 register stages holds
// while its successor is full, so a stall backs up without loss.
// Reset (rst_n low, asynchronous) clears the stage valid bits only; no
// state is kept between transactions.
// ----------------------------------------------------------------------------
// hz_to_mel_converter_unit: Slaney mel scale, Hz to mel
// Linear below 1000 Hz, leading-one log2 with table interpolation above.
// ----------------------------------------------------------------------------
module hz_to_mel_converter_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [h2m_pkg::FREQ_W-1:0]  freq_hz,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [h2m_pkg::MEL_W-1:0]   mel_value,
    output logic                        log_region
);

    localparam int S = h2m_pkg::STAGES;

    // stage valid bits and stage ready chain
    logic [S-1:0] vld_reg;
    logic [S-1:0] stage_rdy;

    // stage 0
    logic [h2m_pkg::LIN_A_W-1:0]   lin_a;
    logic [h2m_pkg::POS_W-1:0]     lead_pos;
    logic [h2m_pkg::FRAC_W+h2m_pkg::FREQ_W-1:0] frac_shift;
    logic                          logr_s0_next, logr_s0_reg;
    logic [h2m_pkg::LIN_N_W-1:0]   lin_n_s0_next, lin_n_s0_reg;
    logic [h2m_pkg::E_W-1:0]       e_s0_next, e_s0_reg;
    logic [h2m_pkg::FRAC_W-1:0]    frac_s0_next, frac_s0_reg;

    // stage 1
    logic [h2m_pkg::SCALED_W-1:0]  scaled;
    logic [h2m_pkg::TAB_IDX_W-1:0] tab_idx;
    logic [h2m_pkg::TAB_IDX_W-1:0] tab_idx_hi;
    logic [h2m_pkg::LIN_P_W-1:0]   lin_prod_s1_next, lin_prod_s1_reg;
    logic [h2m_pkg::LIN_N_W-1:0]   lin_n_s1_reg;
    logic                          logr_s1_reg;
    logic [h2m_pkg::E_W-1:0]       e_s1_reg;
    logic [h2m_pkg::Q_FRAC:0]      t0_s1_next, t0_s1_reg;
    logic [h2m_pkg::Q_FRAC:0]      diff_s1_next, diff_s1_reg;
    logic [h2m_pkg::FRAC_W-1:0]    rem_s1_next, rem_s1_reg;

    // stage 2
    logic [h2m_pkg::LIN_Q_W-1:0]   lin_q0;
    logic [h2m_pkg::LIN_N_W-1:0]   lin_r;
    logic [h2m_pkg::LIN_Q_W-1:0]   lin_q_s2_next, lin_q_s2_reg;
    logic [2*h2m_pkg::FRAC_W-1:0]  interp_prod;
    logic [h2m_pkg::Q_FRAC:0]      interp_s2_next, interp_s2_reg;
    logic [h2m_pkg::Q_FRAC:0]      t0_s2_reg;
    logic                          logr_s2_reg;
    logic [h2m_pkg::E_W-1:0]       e_s2_reg;

    // stage 3
    logic [h2m_pkg::Q_FRAC+1:0]    log_frac;
    logic [h2m_pkg::D_W:0]         log_sum;
    logic [h2m_pkg::D_W-1:0]       d_s3_next, d_s3_reg;
    logic [h2m_pkg::MEL_W-1:0]     lin_mel_s3_next, lin_mel_s3_reg;
    logic                          logr_s3_reg;

    // stage 4
    logic [h2m_pkg::PL_W-1:0]      pl_s4_next, pl_s4_reg;
    logic [h2m_pkg::PH_W-1:0]      ph_s4_next, ph_s4_reg;
    logic [h2m_pkg::MEL_W-1:0]     lin_mel_s4_reg;
    logic                          logr_s4_reg;

    // stage 5
    logic [h2m_pkg::P_W:0]         mul_sum;
    logic [h2m_pkg::LOGM_W-1:0]    logm_s5_next, logm_s5_reg;
    logic [h2m_pkg::MEL_W-1:0]     lin_mel_s5_reg;
    logic                          logr_s5_reg;

    // stage 6 (output register)
    logic [h2m_pkg::LOGM_W:0]      log_mel;
    logic [h2m_pkg::MEL_W-1:0]     mel_value_next, mel_value_reg;
    logic                          log_region_reg;

    // ready chain: a stage takes new data when empty or when it moves on
    always_comb
    begin
        stage_rdy[S-1] = !vld_reg[S-1] || out_ready;
        for (int i = S - 2; i >= 0; i--)
            stage_rdy[i] = !vld_reg[i] || stage_rdy[i+1];
    end

    assign in_ready = stage_rdy[0];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < S; i++)
                if (stage_rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 0: region, linear numerator, leading one and mantissa fraction
    always_comb
    begin
        logr_s0_next  = {2'b00, freq_hz} >= h2m_pkg::BREAK_HZ;
        lin_a         = ((h2m_pkg::LIN_A_W'(freq_hz) << 1) + h2m_pkg::LIN_A_W'(freq_hz))
                        << h2m_pkg::OUT_FRAC_BITS;
        lin_a         = lin_a + h2m_pkg::LIN_BIAS;
        lin_n_s0_next = lin_a[h2m_pkg::LIN_A_W-1:h2m_pkg::LIN_SH];
        lead_pos      = '0;
        for (int i = 0; i < h2m_pkg::FREQ_W; i++)
            if (freq_hz[i])
                lead_pos = h2m_pkg::POS_W'(i);
        e_s0_next     = h2m_pkg::E_W'(lead_pos - h2m_pkg::POS_W'(h2m_pkg::E_BASE));
        frac_shift    = {{h2m_pkg::FRAC_W{1'b0}}, freq_hz}
                        << (h2m_pkg::POS_W'(h2m_pkg::FRAC_W) - lead_pos);
        frac_s0_next  = frac_shift[h2m_pkg::FRAC_W-1:0];
    end

    // stage 1: reciprocal product, table index and table lookups
    always_comb
    begin
        lin_prod_s1_next = h2m_pkg::LIN_P_W'(lin_n_s0_reg) *
                           h2m_pkg::LIN_P_W'(h2m_pkg::LIN_RECIP);
        scaled           = h2m_pkg::SCALED_W'(frac_s0_reg) *
                           h2m_pkg::SCALED_W'(h2m_pkg::LOG_TABLE_ENTRIES);
        tab_idx          = scaled[h2m_pkg::SCALED_W-1:h2m_pkg::FRAC_W];
        tab_idx_hi       = tab_idx + 1'b1;
        rem_s1_next      = scaled[h2m_pkg::FRAC_W-1:0];
        t0_s1_next       = h2m_pkg::LOG_TABLE[tab_idx];
        diff_s1_next     = h2m_pkg::LOG_TABLE[tab_idx_hi] - h2m_pkg::LOG_TABLE[tab_idx];
    end

    // stage 2: quotient correction by 25, chord interpolation
    always_comb
    begin
        lin_q0         = lin_prod_s1_reg[h2m_pkg::LIN_P_W-1:h2m_pkg::LIN_N_W];
        lin_r          = lin_n_s1_reg - h2m_pkg::LIN_N_W'(h2m_pkg::LIN_N_W'(lin_q0) *
                                                          h2m_pkg::LIN_N_W'(25));
        lin_q_s2_next  = (lin_r >= h2m_pkg::LIN_N_W'(25)) ? lin_q0 + 1'b1 : lin_q0;
        interp_prod    = (2*h2m_pkg::FRAC_W)'(diff_s1_reg) *
                         (2*h2m_pkg::FRAC_W)'(rem_s1_reg);
        interp_s2_next = interp_prod[2*h2m_pkg::FRAC_W-1:h2m_pkg::FRAC_W];
    end

    // stage 3: log difference with clamp at zero, linear saturation
    always_comb
    begin
        log_frac        = (h2m_pkg::Q_FRAC+2)'(t0_s2_reg) + (h2m_pkg::Q_FRAC+2)'(interp_s2_reg);
        log_sum         = {1'b0, e_s2_reg, {h2m_pkg::Q_FRAC{1'b0}}} +
                          (h2m_pkg::D_W+1)'(log_frac);
        // chord below curve just above the break clamps to zero
        if (log_sum < (h2m_pkg::D_W+1)'(h2m_pkg::LOG_1000_FRAC))
            d_s3_next = '0;
        else
            d_s3_next = h2m_pkg::D_W'(log_sum - (h2m_pkg::D_W+1)'(h2m_pkg::LOG_1000_FRAC));
        if (64'(lin_q_s2_reg) > 64'(h2m_pkg::MEL_MAX))
            lin_mel_s3_next = h2m_pkg::MEL_MAX;
        else
            lin_mel_s3_next = h2m_pkg::MEL_W'(lin_q_s2_reg);
    end

    // stage 4: scale factor product in two halves
    always_comb
    begin
        pl_s4_next = h2m_pkg::PL_W'(d_s3_reg[h2m_pkg::DL_W-1:0]) * h2m_pkg::PL_W'(h2m_pkg::K_Q24);
        ph_s4_next = h2m_pkg::PH_W'(d_s3_reg[h2m_pkg::D_W-1:h2m_pkg::DL_W]) *
                     h2m_pkg::PH_W'(h2m_pkg::K_Q24);
    end

    // stage 5: recombine, round half up and scale to output format
    always_comb
    begin
        mul_sum      = ((h2m_pkg::P_W+1)'(ph_s4_reg) << h2m_pkg::DL_W) +
                       (h2m_pkg::P_W+1)'(pl_s4_reg) + h2m_pkg::MUL_ROUND;
        logm_s5_next = mul_sum[h2m_pkg::P_W:h2m_pkg::MUL_SH];
    end

    // stage 6: add the mel offset at the break, saturate, pick region
    always_comb
    begin
        log_mel = (h2m_pkg::LOGM_W+1)'(logm_s5_reg) +
                  (h2m_pkg::LOGM_W+1)'(h2m_pkg::MEL_BREAK64);
        if (!logr_s5_reg)
            mel_value_next = lin_mel_s5_reg;
        else if (64'(log_mel) > 64'(h2m_pkg::MEL_MAX))
            mel_value_next = h2m_pkg::MEL_MAX;
        else
            mel_value_next = h2m_pkg::MEL_W'(log_mel);
    end

    // payload registers, loaded when the stage advances
    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            logr_s0_reg  <= logr_s0_next;
            lin_n_s0_reg <= lin_n_s0_next;
            e_s0_reg     <= e_s0_next;
            frac_s0_reg  <= frac_s0_next;
        end
        if (stage_rdy[1])
        begin
            lin_prod_s1_reg <= lin_prod_s1_next;
            lin_n_s1_reg    <= lin_n_s0_reg;
            logr_s1_reg     <= logr_s0_reg;
            e_s1_reg        <= e_s0_reg;
            t0_s1_reg       <= t0_s1_next;
            diff_s1_reg     <= diff_s1_next;
            rem_s1_reg      <= rem_s1_next;
        end
        if (stage_rdy[2])
        begin
            lin_q_s2_reg  <= lin_q_s2_next;
            interp_s2_reg <= interp_s2_next;
            t0_s2_reg     <= t0_s1_reg;
            logr_s2_reg   <= logr_s1_reg;
            e_s2_reg      <= e_s1_reg;
        end
        if (stage_rdy[3])
        begin
            d_s3_reg       <= d_s3_next;
            lin_mel_s3_reg <= lin_mel_s3_next;
            logr_s3_reg    <= logr_s2_reg;
        end
        if (stage_rdy[4])
        begin
            pl_s4_reg      <= pl_s4_next;
            ph_s4_reg      <= ph_s4_next;
            lin_mel_s4_reg <= lin_mel_s3_reg;
            logr_s4_reg    <= logr_s3_reg;
        end
        if (stage_rdy[5])
        begin
            logm_s5_reg    <= logm_s5_next;
            lin_mel_s5_reg <= lin_mel_s4_reg;
            logr_s5_reg    <= logr_s4_reg;
        end
        if (stage_rdy[6])
        begin
            mel_value_reg  <= mel_value_next;
            log_region_reg <= logr_s5_reg;
        end
    end

    // outputs
    assign out_valid  = vld_reg[S-1];
    assign mel_value  = mel_value_reg;
    assign log_region = log_region_reg;

    // log region never reports less than the mel value at the break
    a_log_above_break: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && log_region |-> mel_value >= h2m_pkg::MEL_AT_BREAK)
        else $error("log region mel below break value");

    // linear region never exceeds the mel value at the break
    a_lin_below_break: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !log_region |-> mel_value <= h2m_pkg::MEL_AT_BREAK)
        else $error("linear region mel above break value");

    // input is refused only when every stage is full and the output stalls
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&vld_reg) && !out_ready)
        else $error("input stalled with room in the pipeline");

    // unstalled, a transaction moves from the first stage to the second, one stage per cycle
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && stage_rdy[1] |=> vld_reg[1])
        else $error("transaction lost between first stages");

endmodule
